FILE: design/lbpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern generator package
// Shared command codes, register indexes, mode codes and the structs that
// pass configuration, blinker step results and status between the modules.
// ----------------------------------------------------------------------------
package lbpg_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // fixed field widths
   localparam int MODE_BITS    = 2;
   localparam int DELAY_BITS   = 16;
   localparam int RATIO_BITS   = 9;
   localparam int PLEN_BITS    = 4;
   localparam int SEG_IDX_BITS = 3;
   localparam int PROD_BITS    = RATIO_BITS + DELAY_BITS;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ON_RATIO     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH = 3'd5;

   // blink modes (code three behaves as even mode)
   localparam logic [MODE_BITS-1:0] MODE_EVEN    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RATIO   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PATTERN = 2'd2;

   // register reset values
   localparam logic [MODE_BITS-1:0]  RST_MODE        = MODE_EVEN;
   localparam logic [DELAY_BITS-1:0] RST_PERIOD      = 16'd1000;
   localparam logic [RATIO_BITS-1:0] RST_ON_RATIO    = 9'd128;
   localparam logic [PLEN_BITS-1:0]  RST_PATTERN_LEN = 4'd2;

   // ratio ceiling: the on time equals the full period
   localparam logic [RATIO_BITS-1:0] RATIO_FULL = 9'd256;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_BLIP    = 2'd1,
      CMD_ENABLE  = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BLIP_IDLE = 2'd0,
      BLIP_OFF  = 2'd1,
      BLIP_ON   = 2'd2
   } blip_phase_type;

   // settled configuration seen by the blinker
   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [DELAY_BITS-1:0] period;
      logic [DELAY_BITS-1:0] on_time;
      logic [PLEN_BITS-1:0]  len_eff;
   } cfg_type;

   // outcome of one blinker step
   typedef struct packed {
      logic                    led;
      logic [SEG_IDX_BITS-1:0] seg_index;
      logic [DELAY_BITS-1:0]   delay;
   } fire_type;

   // state visible on the result channel
   typedef struct packed {
      logic led;
      logic running;
      logic blip_busy;
   } status_type;

endpackage
`default_nettype wire

FILE: design/led_blink_pattern_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern generator
// Drives one LED from a stream of tick, blip, enable and restart words.
// ----------------------------------------------------------------------------
// One request word is taken per clock cycle while req_stall is low. A word
// is captured in the input register and processed against the blinker and
// blip state once the result slot is free or being taken; its result word
// then appears on rsp_valid from the state registers, which hold that
// result until it is taken, while a further request may already wait
// in the input register. The ratio-mode on time is worked out from the
// registers through one 9 x 16 multiplier in the same cycle, so a register
// write counts for every word processed after it. There is no clearing
// pass after reset.
module led_blink_pattern_generator #(
   parameter int PATTERN_SLOTS = 8,
   parameter int TIME_BITS     = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_cmd,
   input  wire logic                                req_enable_value,
   input  wire logic [lbpg_pkg::DELAY_BITS-1:0]     req_blip_ms,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_led,
   output logic                                     rsp_blinker_running,
   output logic                                     rsp_blip_busy,
   // configuration port
   input  wire logic                                csr_wr_en,
   input  wire logic [lbpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lbpg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                            in_valid_ff, in_valid_in;
   lbpg_pkg::cmd_type               cmd_ff;
   logic                            enable_ff;
   logic [lbpg_pkg::DELAY_BITS-1:0] blip_ms_ff;
   logic                            out_valid_ff, out_valid_in;
   logic                            req_take;
   logic                            advance;

   lbpg_pkg::cfg_type                                   cfg;
   logic [PATTERN_SLOTS-1:0][lbpg_pkg::DELAY_BITS-1:0]  seg_lens;
   lbpg_pkg::status_type                                status;

   // handshake: the held word moves on when the result slot is free or taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= lbpg_pkg::cmd_type'(req_cmd);
         enable_ff  <= req_enable_value;
         blip_ms_ff <= req_blip_ms;
      end
   end

   lbpg_csr #(
      .PATTERN_SLOTS(PATTERN_SLOTS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg),
      .seg_lens (seg_lens)
   );

   lbpg_engine #(
      .PATTERN_SLOTS(PATTERN_SLOTS),
      .TIME_BITS    (TIME_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .go          (advance),
      .cmd         (cmd_ff),
      .enable_value(enable_ff),
      .blip_ms     (blip_ms_ff),
      .cfg         (cfg),
      .seg_lens    (seg_lens),
      .status      (status)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_led             = status.led;
   assign rsp_blinker_running = status.running;
   assign rsp_blip_busy       = status.blip_busy;

   // a processed word always lands in the result slot
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed word did not produce a result");

   // the request side only stalls with a word already held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   // state only moves when a word is processed
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      (!reset && !advance) |=>
         ($stable(rsp_led) && $stable(rsp_blinker_running) && $stable(rsp_blip_busy)))
      else $error("result state changed without a processed word");

endmodule
`default_nettype wire

FILE: design/lbpg_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern generator configuration registers
// Holds the registers written over the configuration port, the segment
// lengths, and the ratio-mode on time derived from them.
// ----------------------------------------------------------------------------
module lbpg_csr #(
   parameter int PATTERN_SLOTS = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_wr_en,
   input  wire logic [lbpg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [lbpg_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   output lbpg_pkg::cfg_type                             cfg,
   output logic [PATTERN_SLOTS-1:0][lbpg_pkg::DELAY_BITS-1:0] seg_lens
);

   logic [lbpg_pkg::MODE_BITS-1:0]  mode_ff;
   logic [lbpg_pkg::DELAY_BITS-1:0] period_ff;
   logic [lbpg_pkg::RATIO_BITS-1:0] ratio_ff;
   logic [lbpg_pkg::PLEN_BITS-1:0]  plen_ff;
   logic [lbpg_pkg::DELAY_BITS-1:0] on_time;
   logic [lbpg_pkg::RATIO_BITS-1:0] ratio_sat;
   logic [lbpg_pkg::PROD_BITS-1:0]  ratio_prod;
   logic [lbpg_pkg::PLEN_BITS-1:0]  len_eff;
   logic [lbpg_pkg::DELAY_BITS-1:0] seg_ff [PATTERN_SLOTS];

   // scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lbpg_pkg::RST_MODE;
         period_ff <= lbpg_pkg::RST_PERIOD;
         ratio_ff  <= lbpg_pkg::RST_ON_RATIO;
         plen_ff   <= lbpg_pkg::RST_PATTERN_LEN;
      end else if (csr_wr_en) begin
         case (csr_index)
            lbpg_pkg::REG_MODE:        mode_ff   <= csr_wdata[lbpg_pkg::MODE_BITS-1:0];
            lbpg_pkg::REG_PERIOD:      period_ff <= csr_wdata[lbpg_pkg::DELAY_BITS-1:0];
            lbpg_pkg::REG_ON_RATIO:    ratio_ff  <= csr_wdata[lbpg_pkg::RATIO_BITS-1:0];
            lbpg_pkg::REG_PATTERN_LEN: plen_ff   <= csr_wdata[lbpg_pkg::PLEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // segment lengths: slots 0-3 from the low word, 4-7 from the high word
   for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_seg
      localparam int Lane = s % 4;
      localparam logic [lbpg_pkg::CSR_INDEX_BITS-1:0] SrcReg =
         (s >= 4) ? lbpg_pkg::REG_PATTERN_HIGH : lbpg_pkg::REG_PATTERN_LOW;

      always_ff @(posedge clock) begin
         if (reset) begin
            seg_ff[s] <= '0;
         end else if (csr_wr_en && (csr_index == SrcReg)) begin
            seg_ff[s] <= csr_wdata[Lane*lbpg_pkg::DELAY_BITS +: lbpg_pkg::DELAY_BITS];
         end
      end

      assign seg_lens[s] = seg_ff[s];
   end

   // ratio-mode on time, (ratio * period) >> 8, straight from the registers
   assign ratio_sat  = (ratio_ff > lbpg_pkg::RATIO_FULL) ? lbpg_pkg::RATIO_FULL : ratio_ff;
   assign ratio_prod = lbpg_pkg::PROD_BITS'(ratio_sat) * lbpg_pkg::PROD_BITS'(period_ff);
   assign on_time    = ratio_prod[lbpg_pkg::DELAY_BITS+7:8];

   // pattern length clamped to 1..PATTERN_SLOTS
   always_comb begin
      if (plen_ff == '0) begin
         len_eff = lbpg_pkg::PLEN_BITS'(1);
      end else if (plen_ff > lbpg_pkg::PLEN_BITS'(PATTERN_SLOTS)) begin
         len_eff = lbpg_pkg::PLEN_BITS'(PATTERN_SLOTS);
      end else begin
         len_eff = plen_ff;
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.period  = period_ff;
   assign cfg.on_time = on_time;
   assign cfg.len_eff = len_eff;

endmodule
`default_nettype wire

FILE: design/lbpg_blinker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern generator blinker step
// Works out the new LED level, segment index and wait length of one
// blinker step from the current level, index and configuration.
// ----------------------------------------------------------------------------
module lbpg_blinker #(
   parameter int PATTERN_SLOTS = 8
) (
   input  wire lbpg_pkg::cfg_type                             cfg,
   input  wire logic [PATTERN_SLOTS-1:0][lbpg_pkg::DELAY_BITS-1:0] seg_lens,
   input  wire logic                                          led_cur,
   input  wire logic [lbpg_pkg::SEG_IDX_BITS-1:0]             idx_cur,
   output lbpg_pkg::fire_type                                 fire
);

   localparam int SegSelBits = $clog2(PATTERN_SLOTS);

   logic [lbpg_pkg::SEG_IDX_BITS-1:0] idx_wrap;
   logic                              led_toggle;

   // an index at or past the active length starts over at the first segment
   assign idx_wrap   = ({1'b0, idx_cur} >= cfg.len_eff) ? '0 : idx_cur;
   assign led_toggle = ~led_cur;

   always_comb begin
      case (cfg.mode)
         lbpg_pkg::MODE_PATTERN: begin
            fire.led       = ~idx_wrap[0];
            fire.delay     = seg_lens[idx_wrap[SegSelBits-1:0]];
            fire.seg_index = idx_wrap + lbpg_pkg::SEG_IDX_BITS'(1);
         end
         lbpg_pkg::MODE_RATIO: begin
            fire.led       = led_toggle;
            fire.delay     = led_toggle ? cfg.on_time : (cfg.period - cfg.on_time);
            fire.seg_index = idx_cur;
         end
         default: begin
            fire.led       = led_toggle;
            fire.delay     = cfg.period;
            fire.seg_index = idx_cur;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/lbpg_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern generator engine
// Holds the blinker and blip state and applies one command word per
// go cycle: blinker step first, then the blip sequencer.
// ----------------------------------------------------------------------------
module lbpg_engine #(
   parameter int PATTERN_SLOTS = 8,
   parameter int TIME_BITS     = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          go,
   input  wire lbpg_pkg::cmd_type                             cmd,
   input  wire logic                                          enable_value,
   input  wire logic [lbpg_pkg::DELAY_BITS-1:0]               blip_ms,
   input  wire lbpg_pkg::cfg_type                             cfg,
   input  wire logic [PATTERN_SLOTS-1:0][lbpg_pkg::DELAY_BITS-1:0] seg_lens,
   output lbpg_pkg::status_type                               status
);

   logic                              led_ff, led_in;
   logic                              running_ff, running_in;
   logic                              armed_ff, armed_in;
   logic [TIME_BITS-1:0]              rem_ff, rem_in;
   logic [lbpg_pkg::SEG_IDX_BITS-1:0] idx_ff, idx_in;
   lbpg_pkg::blip_phase_type          phase_ff, phase_in;
   logic [TIME_BITS-1:0]              brem_ff, brem_in;
   logic                              saved_ff, saved_in;
   logic                              touched_ff, touched_in;
   logic [lbpg_pkg::DELAY_BITS-1:0]   blen_ff, blen_in;

   logic                              do_fire;
   logic [lbpg_pkg::SEG_IDX_BITS-1:0] fire_idx_cur;
   lbpg_pkg::fire_type                fire;

   // wait length cut to the timer width; zero counts as one tick
   function automatic logic [TIME_BITS-1:0] clip_wait(input logic [lbpg_pkg::DELAY_BITS-1:0] d);
      logic [TIME_BITS-1:0] t;
      t = TIME_BITS'(d);
      return (t == '0) ? TIME_BITS'(1) : t;
   endfunction

   // restart steps from the first segment
   assign fire_idx_cur = (cmd == lbpg_pkg::CMD_RESTART) ? '0 : idx_ff;

   lbpg_blinker #(
      .PATTERN_SLOTS(PATTERN_SLOTS)
   ) u_blinker (
      .cfg     (cfg),
      .seg_lens(seg_lens),
      .led_cur (led_ff),
      .idx_cur (fire_idx_cur),
      .fire    (fire)
   );

   // next state
   always_comb begin
      led_in     = led_ff;
      running_in = running_ff;
      armed_in   = armed_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      phase_in   = phase_ff;
      brem_in    = brem_ff;
      saved_in   = saved_ff;
      touched_in = touched_ff;
      blen_in    = blen_ff;
      do_fire    = 1'b0;

      if (go) begin
         // command decode
         case (cmd)
            lbpg_pkg::CMD_TICK: begin
               if (armed_ff) begin
                  rem_in = rem_ff - TIME_BITS'(1);
                  if (rem_in == '0) begin
                     armed_in = 1'b0;
                     do_fire  = running_ff;
                  end
               end
            end
            lbpg_pkg::CMD_BLIP: begin
               if (phase_ff == lbpg_pkg::BLIP_IDLE) begin
                  saved_in   = led_ff;
                  led_in     = 1'b0;
                  touched_in = 1'b0;
                  blen_in    = blip_ms;
                  phase_in   = lbpg_pkg::BLIP_OFF;
                  brem_in    = clip_wait(blip_ms);
               end
            end
            lbpg_pkg::CMD_ENABLE: begin
               running_in = enable_value;
               if (enable_value) begin
                  do_fire = 1'b1;
               end else begin
                  led_in   = 1'b0;
                  armed_in = 1'b0;
                  rem_in   = '0;
                  if (phase_ff != lbpg_pkg::BLIP_IDLE) begin
                     touched_in = 1'b1;
                  end
               end
            end
            lbpg_pkg::CMD_RESTART: begin
               if (cfg.mode == lbpg_pkg::MODE_PATTERN) begin
                  idx_in = '0;
                  if (armed_ff) begin
                     armed_in = 1'b0;
                     rem_in   = '0;
                     do_fire  = running_ff;
                  end
               end
            end
            default: ;
         endcase

         // blinker step
         if (do_fire) begin
            led_in   = fire.led;
            idx_in   = fire.seg_index;
            armed_in = 1'b1;
            rem_in   = clip_wait(fire.delay);
            if (phase_ff != lbpg_pkg::BLIP_IDLE) begin
               touched_in = 1'b1;
            end
         end

         // blip sequencer runs after the blinker on a tick
         if ((cmd == lbpg_pkg::CMD_TICK) && (phase_ff != lbpg_pkg::BLIP_IDLE)) begin
            brem_in = brem_ff - TIME_BITS'(1);
            if (brem_in == '0) begin
               if (touched_in) begin
                  phase_in = lbpg_pkg::BLIP_IDLE;
               end else begin
                  case (phase_ff)
                     lbpg_pkg::BLIP_OFF: begin
                        led_in   = 1'b1;
                        phase_in = lbpg_pkg::BLIP_ON;
                        brem_in  = clip_wait(blen_ff);
                     end
                     lbpg_pkg::BLIP_ON: begin
                        led_in   = saved_ff;
                        phase_in = lbpg_pkg::BLIP_IDLE;
                     end
                     default: begin
                        phase_in = lbpg_pkg::BLIP_IDLE;
                     end
                  endcase
               end
            end
         end
      end
   end

   // state registers; they also serve as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff     <= 1'b0;
         running_ff <= 1'b0;
         armed_ff   <= 1'b0;
         rem_ff     <= '0;
         idx_ff     <= '0;
         phase_ff   <= lbpg_pkg::BLIP_IDLE;
         brem_ff    <= '0;
         saved_ff   <= 1'b0;
         touched_ff <= 1'b0;
         blen_ff    <= '0;
      end else begin
         led_ff     <= led_in;
         running_ff <= running_in;
         armed_ff   <= armed_in;
         rem_ff     <= rem_in;
         idx_ff     <= idx_in;
         phase_ff   <= phase_in;
         brem_ff    <= brem_in;
         saved_ff   <= saved_in;
         touched_ff <= touched_in;
         blen_ff    <= blen_in;
      end
   end

   // outputs
   assign status.led       = led_ff;
   assign status.running   = running_ff;
   assign status.blip_busy = (phase_ff != lbpg_pkg::BLIP_IDLE);

endmodule
`default_nettype wire
